// File: design/pft_pkg.sv
package pft_pkg;

    localparam int MAX_FACE_VERTS = 16;
    localparam int COORD_WIDTH    = 16;
    localparam int TRI_VERTS      = 3;
    localparam int QUAD_VERTS     = 4;

endpackage

// File: design/pft_if.sv
interface pft_vin_if #(parameter int CW = pft_pkg::COORD_WIDTH);
    logic          valid;
    logic          ready;
    logic [CW-1:0] vertex_x;
    logic [CW-1:0] vertex_y;
    logic [CW-1:0] vertex_z;
    logic          face_end;
    modport source (output valid, vertex_x, vertex_y, vertex_z, face_end, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z, face_end, output ready);
endinterface

interface pft_tri_if #(parameter int CW = pft_pkg::COORD_WIDTH);
    logic            valid;
    logic            ready;
    logic [CW-1:0]   out_x;
    logic [CW-1:0]   out_y;
    logic [CW-1:0]   out_z;
    logic [2*CW+3:0] normal_x;
    logic [2*CW+3:0] normal_y;
    logic [2*CW+3:0] normal_z;
    logic            run_last;
    modport source (output valid, out_x, out_y, out_z, normal_x, normal_y, normal_z,
                    run_last, input ready);
    modport sink   (input valid, out_x, out_y, out_z, normal_x, normal_y, normal_z,
                    run_last, output ready);
endinterface

// File: design/polygon_face_triangulator.sv
// Polygon face triangulator.
// vin: one vertex word per face vertex, face_end on the last one. tris: triangle
// vertex words, each with the cross-product normal of its triangle, run_last
// on the final word of a face. Vertices are written into a vertex RAM at one
// per cycle while vin is ready. On the last vertex the block stops taking
// input and emits the face. For a fan face it first runs three serial
// dividers for the centroid. Then, for each triangle, it reads the corners
// from the one RAM read port (two in a fan, whose third corner is the
// centroid, three otherwise) and forms the products. It then sends three
// words, one per cycle while the receiver keeps up, and takes the normal
// difference with the first word.
// A stalled receiver holds the output register and halts the sequencer; vin
// stays low until the face is sent. Faces of fewer than three vertices or
// more than MAX_FACE_VERTS give no words. Reset empties the face and the
// output; the RAM contents need no clearing.
module polygon_face_triangulator #(
    parameter int MAX_FACE_VERTS = pft_pkg::MAX_FACE_VERTS,
    parameter int COORD_WIDTH    = pft_pkg::COORD_WIDTH
) (
    input logic clk,
    input logic rst_n,
    pft_vin_if.sink   vin,
    pft_tri_if.source tris
);

    localparam int CW  = COORD_WIDTH;
    localparam int NW  = 2 * CW + 4;
    localparam int AW  = $clog2(MAX_FACE_VERTS);
    localparam int NCW = $clog2(MAX_FACE_VERTS + 1);
    localparam int SW  = CW + NCW;
    localparam int DW  = CW + 1;

    localparam logic [3:0] S_IN   = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_RDA  = 4'd2;
    localparam logic [3:0] S_RDB  = 4'd3;
    localparam logic [3:0] S_RDC  = 4'd4;
    localparam logic [3:0] S_LATC = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    logic [3:0]     state_reg, state_next;
    logic [NCW-1:0] cnt_reg, cnt_next;
    logic           ovf_reg, ovf_next;
    logic [SW-1:0]  sx_reg, sy_reg, sz_reg;
    logic [SW-1:0]  sx_next, sy_next, sz_next;
    logic [NCW-1:0] tri_reg, tri_next;
    logic [1:0]     corner_reg, corner_next;
    logic [CW-1:0]  ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic [CW-1:0]  cx_reg, cy_reg, cz_reg;
    logic [CW-1:0]  mx_reg, my_reg, mz_reg;
    logic [NW-1:0]  p_reg [6];
    logic [NW-1:0]  nx_reg, ny_reg, nz_reg;
    logic           ovalid_reg;
    logic [CW-1:0]  ox_reg, oy_reg, oz_reg;
    logic           olast_reg;

    logic            wr_en;
    logic [AW-1:0]   rd_addr;
    logic [3*CW-1:0] rd_data;
    logic            div_start, div_busy;
    logic [SW-1:0]   qx, qy, qz;
    logic            out_free, fan, last_tri;
    logic [NCW-1:0]  idx_a, idx_b, idx_c;
    logic [DW-1:0]   ux, uy, uz, vx, vy, vz;

    assign out_free  = !ovalid_reg || tris.ready;
    assign vin.ready = (state_reg == S_IN);
    assign wr_en     = vin.valid && vin.ready && (cnt_reg < NCW'(MAX_FACE_VERTS));
    assign fan       = (cnt_reg > NCW'(pft_pkg::QUAD_VERTS));
    assign last_tri  = fan ? (tri_reg == cnt_reg - 1'b1)
                           : (cnt_reg == NCW'(pft_pkg::TRI_VERTS) || tri_reg == NCW'(1));

    // pick corner indexes of the current triangle
    always_comb
    begin
        if (fan)
        begin
            idx_a = tri_reg;
            idx_b = (tri_reg == cnt_reg - 1'b1) ? '0 : tri_reg + 1'b1;
            idx_c = '0;
        end
        else if (tri_reg == '0)
        begin
            idx_a = '0;
            idx_b = NCW'(1);
            idx_c = NCW'(2);
        end
        else
        begin
            idx_a = NCW'(2);
            idx_b = NCW'(3);
            idx_c = '0;
        end
    end

    always_comb
    begin
        case (state_reg)
            S_RDA:   rd_addr = idx_a[AW-1:0];
            S_RDB:   rd_addr = idx_b[AW-1:0];
            default: rd_addr = idx_c[AW-1:0];
        endcase
    end

    pft_ram #(.WIDTH(3 * CW), .DEPTH(MAX_FACE_VERTS)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data ({vin.vertex_x, vin.vertex_y, vin.vertex_z}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pft_div #(.NW(SW), .DW(NCW)) u_divx (.clk(clk), .rst_n(rst_n), .start(div_start),
        .num(sx_reg), .den(cnt_reg), .busy(div_busy), .quo(qx));
    pft_div #(.NW(SW), .DW(NCW)) u_divy (.clk(clk), .rst_n(rst_n), .start(div_start),
        .num(sy_reg), .den(cnt_reg), .busy(), .quo(qy));
    pft_div #(.NW(SW), .DW(NCW)) u_divz (.clk(clk), .rst_n(rst_n), .start(div_start),
        .num(sz_reg), .den(cnt_reg), .busy(), .quo(qz));

    // edge vectors
    assign ux = DW'($signed(bx_reg)) - DW'($signed(ax_reg));
    assign uy = DW'($signed(by_reg)) - DW'($signed(ay_reg));
    assign uz = DW'($signed(bz_reg)) - DW'($signed(az_reg));
    assign vx = DW'($signed(cx_reg)) - DW'($signed(ax_reg));
    assign vy = DW'($signed(cy_reg)) - DW'($signed(ay_reg));
    assign vz = DW'($signed(cz_reg)) - DW'($signed(az_reg));

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        sz_next     = sz_reg;
        tri_next    = tri_reg;
        corner_next = corner_reg;
        div_start   = 1'b0;
        case (state_reg)
            S_IN:
            begin
                if (vin.valid)
                begin
                    if (wr_en)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        sx_next  = sx_reg + SW'($signed(vin.vertex_x));
                        sy_next  = sy_reg + SW'($signed(vin.vertex_y));
                        sz_next  = sz_reg + SW'($signed(vin.vertex_z));
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (vin.face_end)
                    begin
                        tri_next = '0;
                        if (!wr_en || ovf_reg || cnt_next < NCW'(pft_pkg::TRI_VERTS))
                        begin
                            cnt_next = '0;
                            ovf_next = 1'b0;
                            sx_next  = '0;
                            sy_next  = '0;
                            sz_next  = '0;
                        end
                        else if (cnt_next > NCW'(pft_pkg::QUAD_VERTS))
                        begin
                            state_next = S_DIV;
                        end
                        else
                        begin
                            state_next = S_RDA;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_busy)
                begin
                    state_next = S_LATC;
                end
                else
                begin
                    div_start  = 1'b1;
                end
            end
            S_LATC:
            begin
                if (!div_busy)
                begin
                    state_next = S_RDA;
                end
            end
            S_RDA:   state_next = S_RDB;
            S_RDB:   state_next = fan ? S_MUL : S_RDC;
            S_RDC:   state_next = S_MUL;
            S_MUL:   state_next = S_ADD;
            S_ADD:
            begin
                state_next  = S_EMIT;
                corner_next = '0;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    corner_next = corner_reg + 1'b1;
                    if (corner_reg == 2'd2)
                    begin
                        if (last_tri)
                        begin
                            state_next = S_IN;
                            cnt_next   = '0;
                            ovf_next   = 1'b0;
                            sx_next    = '0;
                            sy_next    = '0;
                            sz_next    = '0;
                        end
                        else
                        begin
                            state_next = S_RDA;
                            tri_next   = tri_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = S_IN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IN;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            sx_reg     <= '0;
            sy_reg     <= '0;
            sz_reg     <= '0;
            tri_reg    <= '0;
            corner_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            sx_reg     <= sx_next;
            sy_reg     <= sy_next;
            sz_reg     <= sz_next;
            tri_reg    <= tri_next;
            corner_reg <= corner_next;
            if (state_reg == S_EMIT && out_free)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (tris.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // corner latches, products, normal and output word
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LATC && !div_busy)
        begin
            mx_reg <= qx[CW-1:0];
            my_reg <= qy[CW-1:0];
            mz_reg <= qz[CW-1:0];
        end
        if (state_reg == S_RDB)
        begin
            {ax_reg, ay_reg, az_reg} <= rd_data;
        end
        if (state_reg == S_RDC)
        begin
            {bx_reg, by_reg, bz_reg} <= rd_data;
        end
        if (state_reg == S_RDB && fan)
        begin
            cx_reg <= mx_reg;
            cy_reg <= my_reg;
            cz_reg <= mz_reg;
        end
        if (state_reg == S_MUL)
        begin
            if (fan)
            begin
                {bx_reg, by_reg, bz_reg} <= rd_data;
            end
            else
            begin
                {cx_reg, cy_reg, cz_reg} <= rd_data;
            end
        end
        if (state_reg == S_ADD)
        begin
            p_reg[0] <= NW'($signed(uy) * $signed(vz));
            p_reg[1] <= NW'($signed(uz) * $signed(vy));
            p_reg[2] <= NW'($signed(uz) * $signed(vx));
            p_reg[3] <= NW'($signed(ux) * $signed(vz));
            p_reg[4] <= NW'($signed(ux) * $signed(vy));
            p_reg[5] <= NW'($signed(uy) * $signed(vx));
        end
        if (state_reg == S_EMIT && corner_reg == 2'd0 && out_free)
        begin
            nx_reg <= p_reg[0] - p_reg[1];
            ny_reg <= p_reg[2] - p_reg[3];
            nz_reg <= p_reg[4] - p_reg[5];
        end
        if (state_reg == S_EMIT && out_free)
        begin
            case (corner_reg)
                2'd0:    {ox_reg, oy_reg, oz_reg} <= {ax_reg, ay_reg, az_reg};
                2'd1:    {ox_reg, oy_reg, oz_reg} <= {bx_reg, by_reg, bz_reg};
                default: {ox_reg, oy_reg, oz_reg} <= {cx_reg, cy_reg, cz_reg};
            endcase
            olast_reg <= (corner_reg == 2'd2) && last_tri;
        end
    end

    assign tris.valid    = ovalid_reg;
    assign tris.out_x    = ox_reg;
    assign tris.out_y    = oy_reg;
    assign tris.out_z    = oz_reg;
    assign tris.normal_x = nx_reg;
    assign tris.normal_y = ny_reg;
    assign tris.normal_z = nz_reg;
    assign tris.run_last = olast_reg;

endmodule

// File: design/pft_ram.sv
module pft_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: design/pft_div.sv
// signed restoring divider, truncates toward zero, one quotient bit a cycle
module pft_div #(
    parameter int NW = 21,
    parameter int DW = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [NW:0]   r_reg, r_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic          busy_reg, busy_next;
    logic [NW:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        trial     = {r_reg[NW-1:0], q_reg[NW-1]} - {{(NW+1-DW){1'b0}}, den};
        if (start)
        begin
            neg_next  = num[NW-1];
            q_next    = num[NW-1] ? (~num + 1'b1) : num;
            r_next    = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one bit, subtract when it fits
            if (!trial[NW])
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[NW-1:0], q_reg[NW-1]};
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                if (neg_reg)
                begin
                    q_next = ~q_next + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign quo  = q_reg;

endmodule

// File: sim/polygon_face_triangulator_tb.sv
`timescale 1ns / 1ps

module polygon_face_triangulator_tb;

    localparam int NW = 2 * pft_pkg::COORD_WIDTH + 4;

    typedef struct packed {
        logic signed [pft_pkg::COORD_WIDTH-1:0] x;
        logic signed [pft_pkg::COORD_WIDTH-1:0] y;
        logic signed [pft_pkg::COORD_WIDTH-1:0] z;
    } vert_t;

    typedef struct packed {
        vert_t            p;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [NW-1:0] nz;
        logic             last;
    } tri_word_t;

    logic clk;
    logic rst_n;

    pft_vin_if vin_bus ();
    pft_tri_if tri_bus ();

    polygon_face_triangulator dut (clk, rst_n, vin_bus, tri_bus);

    tri_word_t expected_words[$];
    vert_t     face_verts[$];
    longint    sum_x, sum_y, sum_z;
    bit        face_overflow;
    int        error_count = 0;
    bit        tx_idle_on = 1;
    bit        rx_idle_on = 1;
    int        hold_cycles = 0;
    int        rx_wait = 0;

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // expected words for one triangle
    function automatic void push_triangle(input vert_t a, input vert_t b, input vert_t c);
        longint ux, uy, uz, vx, vy, vz;
        tri_word_t w;
        ux = longint'(b.x) - longint'(a.x);
        uy = longint'(b.y) - longint'(a.y);
        uz = longint'(b.z) - longint'(a.z);
        vx = longint'(c.x) - longint'(a.x);
        vy = longint'(c.y) - longint'(a.y);
        vz = longint'(c.z) - longint'(a.z);
        w.nx = NW'(uy * vz - uz * vy);
        w.ny = NW'(uz * vx - ux * vz);
        w.nz = NW'(ux * vy - uy * vx);
        w.last = 0;
        w.p = a;
        expected_words = {expected_words, w};
        w.p = b;
        expected_words = {expected_words, w};
        w.p = c;
        expected_words = {expected_words, w};
    endfunction

    // store one accepted vertex; on face end emit the face
    function automatic void predict_vertex(input vert_t p, input bit last);
        int n;
        vert_t ctr;
        if (face_verts.size() < pft_pkg::MAX_FACE_VERTS)
        begin
            face_verts = {face_verts, p};
            sum_x += p.x;
            sum_y += p.y;
            sum_z += p.z;
        end
        else
            face_overflow = 1;
        if (!last)
            return;
        n = face_verts.size();
        if (!face_overflow && n >= pft_pkg::TRI_VERTS)
        begin
            if (n == pft_pkg::TRI_VERTS)
                push_triangle(face_verts[0], face_verts[1], face_verts[2]);
            else if (n == pft_pkg::QUAD_VERTS)
            begin
                push_triangle(face_verts[0], face_verts[1], face_verts[2]);
                push_triangle(face_verts[2], face_verts[3], face_verts[0]);
            end
            else
            begin
                ctr.x = pft_pkg::COORD_WIDTH'(sum_x / longint'(n));
                ctr.y = pft_pkg::COORD_WIDTH'(sum_y / longint'(n));
                ctr.z = pft_pkg::COORD_WIDTH'(sum_z / longint'(n));
                for (int i = 0; i < n; i++)
                    push_triangle(face_verts[i], face_verts[(i + 1) % n], ctr);
            end
            expected_words[$].last = 1;
        end
        face_verts.delete();
        sum_x = 0;
        sum_y = 0;
        sum_z = 0;
        face_overflow = 0;
    endfunction

    // offer one vertex word and wait for it to be taken
    task automatic send_vertex(input vert_t p, input bit last);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            vin_bus.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        vin_bus.valid    <= 1;
        vin_bus.vertex_x <= p.x;
        vin_bus.vertex_y <= p.y;
        vin_bus.vertex_z <= p.z;
        vin_bus.face_end <= last;
        @(posedge clk);
        while (!vin_bus.ready)
            @(posedge clk);
        predict_vertex(p, last);
    endtask

    function automatic vert_t rand_vert(input bit narrow);
        vert_t p;
        if (narrow)
        begin
            p.x = pft_pkg::COORD_WIDTH'(int'($urandom_range(0, 2047)) - 1024);
            p.y = pft_pkg::COORD_WIDTH'(int'($urandom_range(0, 2047)) - 1024);
            p.z = pft_pkg::COORD_WIDTH'(int'($urandom_range(0, 2047)) - 1024);
        end
        else
        begin
            p.x = pft_pkg::COORD_WIDTH'($urandom);
            p.y = pft_pkg::COORD_WIDTH'($urandom);
            p.z = pft_pkg::COORD_WIDTH'($urandom);
        end
        return p;
    endfunction

    task automatic send_face(input int n);
        bit narrow;
        narrow = $urandom_range(0, 1);
        for (int i = 0; i < n; i++)
            send_vertex(rand_vert(narrow), i == n - 1);
    endtask

    // directed: extremes, each face shape, short faces
    task automatic test_directed();
        vert_t lo, hi, mx;
        lo = '{x: -32768, y: -32768, z: -32768};
        hi = '{x: 32767, y: 32767, z: 32767};
        mx = '{x: 32767, y: -32768, z: 0};
        send_vertex(lo, 0);
        send_vertex(hi, 0);
        send_vertex(mx, 1);
        send_vertex('{x: 32767, y: -32768, z: -32768}, 0);
        send_vertex('{x: -32768, y: 32767, z: -32768}, 0);
        send_vertex('{x: -32768, y: -32768, z: 32767}, 0);
        send_vertex(hi, 1);
        send_vertex(lo, 0);
        send_vertex(hi, 0);
        send_vertex(mx, 0);
        send_vertex('{x: -1, y: 1, z: -3}, 0);
        send_vertex('{x: -32768, y: 32767, z: 5}, 1);
        send_vertex(hi, 1);
        send_vertex(lo, 0);
        send_vertex(hi, 1);
    endtask

    // store full, then one past full, then a triangle
    task automatic test_store_limits();
        send_face(pft_pkg::MAX_FACE_VERTS);
        send_face(pft_pkg::MAX_FACE_VERTS + 1);
        send_face(3);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        hold_cycles = 400;
        tx_idle_on = 0;
        send_face(8);
        send_face(5);
        send_face(4);
        tx_idle_on = 1;
    endtask

    task automatic test_random(input int items);
        int sent, n, pick;
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                n = $urandom_range(1, 2);
            else if (pick == 1)
                n = $urandom_range(pft_pkg::MAX_FACE_VERTS + 1, pft_pkg::MAX_FACE_VERTS + 4);
            else if (pick < 8)
                n = $urandom_range(3, 4);
            else
                n = $urandom_range(5, pft_pkg::MAX_FACE_VERTS);
            if ($urandom_range(0, 9) == 0)
            begin
                tx_idle_on = !tx_idle_on;
                rx_idle_on = !rx_idle_on;
            end
            send_face(n);
            sent += n;
        end
        tx_idle_on = 1;
        rx_idle_on = 1;
    endtask

    // receiver: long hold-off, random stalls, idle-free stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tri_bus.ready <= 0;
        else if (hold_cycles > 0)
        begin
            hold_cycles--;
            tri_bus.ready <= 0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            tri_bus.ready <= (rx_wait == 0);
        end
        else
        begin
            if (tri_bus.valid && tri_bus.ready && rx_idle_on)
                rx_wait = $urandom_range(0, 8);
            tri_bus.ready <= (rx_wait == 0);
        end
    end

    // compare each taken word with the oldest expectation
    always @(posedge clk)
    begin
        tri_word_t w;
        if (rst_n && tri_bus.valid && tri_bus.ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word, run_last", tri_bus.run_last, 0);
            else
            begin
                w = expected_words.pop_front();
                if (tri_bus.out_x !== w.p.x)
                    report_mismatch("out_x", $signed(tri_bus.out_x), w.p.x);
                if (tri_bus.out_y !== w.p.y)
                    report_mismatch("out_y", $signed(tri_bus.out_y), w.p.y);
                if (tri_bus.out_z !== w.p.z)
                    report_mismatch("out_z", $signed(tri_bus.out_z), w.p.z);
                if (tri_bus.normal_x !== w.nx)
                    report_mismatch("normal_x", $signed(tri_bus.normal_x), w.nx);
                if (tri_bus.normal_y !== w.ny)
                    report_mismatch("normal_y", $signed(tri_bus.normal_y), w.ny);
                if (tri_bus.normal_z !== w.nz)
                    report_mismatch("normal_z", $signed(tri_bus.normal_z), w.nz);
                if (tri_bus.run_last !== w.last)
                    report_mismatch("run_last", tri_bus.run_last, w.last);
            end
        end
    end

    // time limit
    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        sum_x = 0;
        sum_y = 0;
        sum_z = 0;
        face_overflow = 0;
        rst_n = 0;
        vin_bus.valid    <= 0;
        vin_bus.vertex_x <= '0;
        vin_bus.vertex_y <= '0;
        vin_bus.vertex_z <= '0;
        vin_bus.face_end <= 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_store_limits();
        test_backpressure();
        test_random(312);
        vin_bus.valid <= 0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: polygon_face_triangulator.f
design/pft_pkg.sv
design/pft_if.sv
design/pft_ram.sv
design/pft_div.sv
design/polygon_face_triangulator.sv
sim/polygon_face_triangulator_tb.sv
